// ===== rtl/pau_pkg.sv =====
// polynomial arithmetic unit: shared constants, request and result types
// no dependencies

package pau_pkg;

  localparam int MAX_DEGREE = 31;
  localparam int DEPTH      = MAX_DEGREE + 1;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(2 * MAX_DEGREE + 1);

  localparam int KIND_W     = 2;
  localparam int FIELD_W    = 5;
  localparam int COEF_W     = 16;
  localparam int OP_W       = 2;
  localparam int POW_W      = 6;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 2 * COEF_W;

  localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START       = 2'd2;

  localparam logic [OP_W-1:0] OP_SUM   = 2'd0;
  localparam logic [OP_W-1:0] OP_DIFF  = 2'd1;
  localparam logic [OP_W-1:0] OP_PROD  = 2'd2;
  localparam logic [OP_W-1:0] OP_DERIV = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [FIELD_W-1:0]       power_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [OP_W-1:0]          operation;
    logic [FIELD_W-1:0]       degree_first;
    logic [FIELD_W-1:0]       degree_second;
  } in_req_t;

  typedef struct packed {
    logic [POW_W-1:0]        result_power;
    logic signed [ACC_W-1:0] result_coef;
    logic                    last_coef;
  } out_res_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic clr;
    logic step;
  } cell_ctl_t;

endpackage

// ===== rtl/polynomial_arithmetic_unit_top.sv =====
// polynomial arithmetic unit top level: sequencer, row of pau_cell, result register
// uses pau_pkg and pau_cell

// A load request stores one coefficient. A start request runs the row of
// multiply-accumulate cells once per result coefficient: while out_stall is
// low, the sequencer broadcasts one value per cycle to every cell, partial sums
// move one cell toward the output each cycle, and one result coefficient reaches
// the result register per cycle. The number of powers fed to the row is the
// larger degree plus one for sum and difference, the sum of the degrees plus one
// for the product and the first degree plus one for the derivative, whose
// constant term is dropped unless the polynomial is a constant. Loads and the
// next start are taken as soon as the last coefficient has left the row.

module polynomial_arithmetic_unit_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pau_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output pau_pkg::out_res_t out_res
);
  import pau_pkg::*;

  logic                     run_r, run_nxt;
  logic                     v1_r, v1_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OP_W-1:0]          op_r;
  logic [IDX_W-1:0]         da_r;
  logic [IDX_W-1:0]         db_r;
  logic [CNT_W-1:0]         top_r;
  logic [CNT_W-1:0]         t_r;
  logic [CNT_W-1:0]         t1_r;
  logic                     last1_r;
  logic signed [COEF_W-1:0] b1_r;
  out_res_t                 out_r;

  logic                     in_acc;
  logic                     start_acc;
  logic                     step;
  logic [IDX_W-1:0]         da_s;
  logic [IDX_W-1:0]         db_s;
  logic [CNT_W-1:0]         top_s;
  logic signed [COEF_W-1:0] b_at_t;
  logic signed [COEF_W-1:0] b_eff;
  logic signed [COEF_W-1:0] x_bc;
  logic                     feed_last;
  cell_ctl_t                ctl;

  logic signed [ACC_W-1:0]  acc_link [0:DEPTH];
  logic signed [COEF_W-1:0] second_vec [0:DEPTH-1];

  logic signed [ACC_W-1:0]          y;
  logic signed [CNT_W+COEF_W:0]     dcoef;
  logic signed [ACC_W-1:0]          coef_sel;
  logic [POW_W-1:0]                 pow_sel;
  logic                             emit;

  assign in_stall  = run_r || v1_r;
  assign in_acc    = in_valid && !in_stall;
  assign start_acc = in_acc && (in_req.kind == KIND_START);
  assign step      = !out_valid_r || !out_stall;

  // degrees above the store depth saturate
  assign da_s = (in_req.degree_first > FIELD_W'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE)
              : in_req.degree_first[IDX_W-1:0];
  assign db_s = (in_req.degree_second > FIELD_W'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE)
              : in_req.degree_second[IDX_W-1:0];

  always_comb begin
    case (in_req.operation)
      OP_SUM, OP_DIFF: top_s = (da_s >= db_s) ? CNT_W'(da_s) : CNT_W'(db_s);
      OP_PROD:         top_s = CNT_W'(da_s) + CNT_W'(db_s);
      OP_DERIV:        top_s = CNT_W'(da_s);
      default:         top_s = '0;
    endcase
  end

  // value fed to the row: second polynomial for the product, a unit pulse otherwise
  assign b_at_t = second_vec[t_r[IDX_W-1:0]];
  assign b_eff  = (t_r <= CNT_W'(db_r)) ? b_at_t : '0;
  always_comb begin
    if (op_r == OP_PROD) begin
      x_bc = b_eff;
    end else if (t_r == '0) begin
      x_bc = COEF_W'(1);
    end else begin
      x_bc = '0;
    end
  end

  assign feed_last = (t_r == top_r);
  assign ctl.clr   = start_acc;
  assign ctl.step  = step;

  assign acc_link[DEPTH] = '0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    pau_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .active     (IDX_W'(j) <= da_r),
      .we_first   (in_acc && (in_req.kind == KIND_LOAD_FIRST) &&
                   (in_req.power_index == FIELD_W'(j))),
      .we_second  (in_acc && (in_req.kind == KIND_LOAD_SECOND) &&
                   (in_req.power_index == FIELD_W'(j))),
      .coef_in    (in_req.coef_value),
      .x_in       (x_bc),
      .acc_in     (acc_link[j+1]),
      .acc_out    (acc_link[j]),
      .second_out (second_vec[j])
    );
  end

  // result formation from the head of the row
  assign y     = acc_link[0];
  assign dcoef = $signed({1'b0, t1_r}) * $signed(y[COEF_W-1:0]);

  always_comb begin
    case (op_r)
      OP_SUM:   coef_sel = y + ACC_W'(b1_r);
      OP_DIFF:  coef_sel = y - ACC_W'(b1_r);
      OP_PROD:  coef_sel = y;
      OP_DERIV: coef_sel = ACC_W'(dcoef);
      default:  coef_sel = y;
    endcase
  end

  // derivative drops the constant term, except for a constant polynomial
  assign emit    = !((op_r == OP_DERIV) && (t1_r == '0) && (da_r != '0));
  assign pow_sel = ((op_r == OP_DERIV) && (t1_r != '0)) ? POW_W'(t1_r - CNT_W'(1))
                 : POW_W'(t1_r);

  always_comb begin
    run_nxt       = run_r;
    v1_nxt        = v1_r;
    out_valid_nxt = out_valid_r;
    if (step) begin
      v1_nxt        = run_r;
      out_valid_nxt = v1_r && emit;
      if (run_r && feed_last) begin
        run_nxt = 1'b0;
      end
    end
    if (start_acc) begin
      run_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      op_r  <= in_req.operation;
      da_r  <= da_s;
      db_r  <= db_s;
      top_r <= top_s;
      t_r   <= '0;
    end else if (step && run_r) begin
      t_r <= t_r + CNT_W'(1);
    end
    if (step) begin
      t1_r    <= t_r;
      last1_r <= feed_last;
      b1_r    <= b_eff;
      if (v1_r) begin
        out_r.result_power <= pow_sel;
        out_r.result_coef  <= coef_sel;
        out_r.last_coef    <= last1_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (t_r <= top_r))
    else $error("sequencer count ran past the last power");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && last1_r) |-> !run_r)
    else $error("row still fed after the last power");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> (run_r && (t_r == '0)))
    else $error("start did not arm the sequencer at power zero");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (step && v1_r && !last1_r) |=> v1_r)
    else $error("gap in the coefficient stream before the last power");

endmodule

// ===== rtl/pau_cell.sv =====
// one cell of the convolution row: holds one coefficient of each polynomial
// and one partial sum of the transposed multiply-accumulate chain; uses pau_pkg

module pau_cell (
  input  logic                              clk,
  input  pau_pkg::cell_ctl_t                ctl,
  input  logic                              active,
  input  logic                              we_first,
  input  logic                              we_second,
  input  logic signed [pau_pkg::COEF_W-1:0] coef_in,
  input  logic signed [pau_pkg::COEF_W-1:0] x_in,
  input  logic signed [pau_pkg::ACC_W-1:0]  acc_in,
  output logic signed [pau_pkg::ACC_W-1:0]  acc_out,
  output logic signed [pau_pkg::COEF_W-1:0] second_out
);
  import pau_pkg::*;

  logic signed [COEF_W-1:0] first_r;
  logic signed [COEF_W-1:0] second_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PROD_W-1:0] prod;

  // coefficient above the degree reads as zero
  assign prod = active ? first_r * x_in : PROD_W'(0);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.step) begin
      acc_nxt = ACC_W'(prod) + acc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (we_first) begin
      first_r <= coef_in;
    end
    if (we_second) begin
      second_r <= coef_in;
    end
    acc_r <= acc_nxt;
  end

  assign acc_out    = acc_r;
  assign second_out = second_r;

endmodule
